// ===== hw/rtl/cvag_pkg.sv =====
package cvag_pkg;

  localparam int DIM_BITS = 12;
  localparam int MAX_ELEMENT_BYTES = 64;
  localparam int EXT_BITS = DIM_BITS + 1;
  localparam int DXY_BITS = 2 * DIM_BITS + 1;
  localparam int INDEX_BITS = 36;
  localparam int BYTE_BITS = 42;
  localparam int EB_BITS = 7;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 13;
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DIM_X = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIM_Y = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIM_Z = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHUNK_X = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHUNK_Y = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHUNK_Z = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ELEMENT_BYTES = 3'd6;

  localparam logic [EXT_BITS-1:0] MAX_DIM = EXT_BITS'(1 << DIM_BITS);
  localparam logic [EB_BITS-1:0] MAX_EB = EB_BITS'(MAX_ELEMENT_BYTES);

  typedef logic [DIM_BITS-1:0] coord_t;
  typedef logic [EXT_BITS-1:0] extent_t;

  typedef struct packed {
    extent_t dx;
    extent_t dy;
    extent_t dz;
    extent_t cx;
    extent_t cy;
    extent_t cz;
  } geom_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic chunk_last;
    logic volume_last;
  } item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] element_index;
    logic [BYTE_BITS-1:0] byte_offset;
    logic chunk_last;
    logic volume_last;
  } result_t;

  function automatic extent_t clamp_dim(input logic [CFG_DATA_BITS-1:0] v);
    extent_t ve;
    ve = EXT_BITS'(v);
    if (v == '0) return EXT_BITS'(1);
    if (EXT_BITS'(v) > MAX_DIM || CFG_DATA_BITS > EXT_BITS && v > CFG_DATA_BITS'(MAX_DIM))
      return MAX_DIM;
    return ve;
  endfunction

  function automatic extent_t clamp_chunk(input logic [CFG_DATA_BITS-1:0] v,
                                          input extent_t d);
    if (v == '0) return EXT_BITS'(1);
    if (EXT_BITS'(v) > d) return d;
    return EXT_BITS'(v);
  endfunction

  function automatic logic [EB_BITS-1:0] clamp_eb(input logic [EB_BITS-1:0] v);
    if (v == '0) return EB_BITS'(1);
    if (v > MAX_EB) return MAX_EB;
    return v;
  endfunction

endpackage

// ===== hw/rtl/cvag_walker.sv =====
module cvag_walker import cvag_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  logic  restart,
  input  geom_t geom,
  input  logic  q_full,
  output logic  q_wr,
  output item_t q_data
);

  coord_t base_x, base_y, base_z;
  coord_t offset_x, offset_y, offset_z;
  coord_t base_x_next, base_y_next, base_z_next;
  coord_t offset_x_next, offset_y_next, offset_z_next;

  logic go1, go2, clast, vlast;
  coord_t bx, by, bz, ox, oy, oz;
  extent_t ex, ey, ez, ex1, ey1, ez1, sum_x, sum_y, sum_z;

  assign q_wr = push && !q_full;

  always_comb begin
    go1 = restart || EXT_BITS'(base_x) >= geom.dx || EXT_BITS'(base_y) >= geom.dy
          || EXT_BITS'(base_z) >= geom.dz;
    bx = go1 ? '0 : base_x;
    by = go1 ? '0 : base_y;
    bz = go1 ? '0 : base_z;
    ox = go1 ? '0 : offset_x;
    oy = go1 ? '0 : offset_y;
    oz = go1 ? '0 : offset_z;
    ex1 = (geom.cx < geom.dx - EXT_BITS'(bx)) ? geom.cx : geom.dx - EXT_BITS'(bx);
    ey1 = (geom.cy < geom.dy - EXT_BITS'(by)) ? geom.cy : geom.dy - EXT_BITS'(by);
    ez1 = (geom.cz < geom.dz - EXT_BITS'(bz)) ? geom.cz : geom.dz - EXT_BITS'(bz);
    go2 = EXT_BITS'(ox) >= ex1 || EXT_BITS'(oy) >= ey1 || EXT_BITS'(oz) >= ez1;
    if (go2) begin
      bx = '0; by = '0; bz = '0;
      ox = '0; oy = '0; oz = '0;
      ex = geom.cx; ey = geom.cy; ez = geom.cz;
    end else begin
      ex = ex1; ey = ey1; ez = ez1;
    end
    sum_x = EXT_BITS'(bx) + geom.cx;
    sum_y = EXT_BITS'(by) + geom.cy;
    sum_z = EXT_BITS'(bz) + geom.cz;
    clast = EXT_BITS'(ox) + EXT_BITS'(1) == ex && EXT_BITS'(oy) + EXT_BITS'(1) == ey
            && EXT_BITS'(oz) + EXT_BITS'(1) == ez;
    vlast = clast && sum_x >= geom.dx && sum_y >= geom.dy && sum_z >= geom.dz;

    q_data.x = bx + ox;
    q_data.y = by + oy;
    q_data.z = bz + oz;
    q_data.chunk_last = clast;
    q_data.volume_last = vlast;

    base_x_next = bx;
    base_y_next = by;
    base_z_next = bz;
    offset_x_next = ox;
    offset_y_next = oy;
    offset_z_next = oz;
    if (!clast) begin
      if (EXT_BITS'(oz) + EXT_BITS'(1) >= ez) begin
        offset_z_next = '0;
        if (EXT_BITS'(oy) + EXT_BITS'(1) >= ey) begin
          offset_y_next = '0;
          offset_x_next = ox + DIM_BITS'(1);
        end else begin
          offset_y_next = oy + DIM_BITS'(1);
        end
      end else begin
        offset_z_next = oz + DIM_BITS'(1);
      end
    end else begin
      offset_x_next = '0;
      offset_y_next = '0;
      offset_z_next = '0;
      if (vlast) begin
        base_x_next = '0;
        base_y_next = '0;
        base_z_next = '0;
      end else if (sum_z >= geom.dz) begin
        base_z_next = '0;
        if (sum_y >= geom.dy) begin
          base_y_next = '0;
          base_x_next = sum_x[DIM_BITS-1:0];
        end else begin
          base_y_next = sum_y[DIM_BITS-1:0];
        end
      end else begin
        base_z_next = sum_z[DIM_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_x <= '0;
      base_y <= '0;
      base_z <= '0;
      offset_x <= '0;
      offset_y <= '0;
      offset_z <= '0;
    end else if (q_wr) begin
      base_x <= base_x_next;
      base_y <= base_y_next;
      base_z <= base_z_next;
      offset_x <= offset_x_next;
      offset_y <= offset_y_next;
      offset_z <= offset_z_next;
    end
  end

endmodule

// ===== hw/rtl/cvag_queue.sv =====
module cvag_queue import cvag_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  item_t wr_data,
  output logic  full,
  input  logic  rd_en,
  output item_t rd_data,
  output logic  empty
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  item_t entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wptr, rptr;
  logic [PTR_BITS:0] count;

  assign full = count == (PTR_BITS + 1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign rd_data = entries[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= wptr + PTR_BITS'(1);
      end
      if (rd_en) begin
        rptr <= rptr + PTR_BITS'(1);
      end
      count <= count + (PTR_BITS + 1)'(wr_en) - (PTR_BITS + 1)'(rd_en);
    end
  end

endmodule

// ===== hw/rtl/cvag_address.sv =====
module cvag_address import cvag_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  extent_t              dx,
  input  logic [DXY_BITS-1:0]  dxdy,
  input  logic [EB_BITS-1:0]   eb,
  input  item_t                q_data,
  input  logic                 q_empty,
  output logic                 q_rd,
  output result_t              res,
  output logic                 empty,
  input  logic                 pop
);

  localparam int OPTR_BITS = $clog2(OUT_DEPTH);
  localparam int YMUL_BITS = DIM_BITS + EXT_BITS;
  localparam int ZMUL_BITS = DIM_BITS + DXY_BITS;
  localparam int BMUL_BITS = INDEX_BITS + EB_BITS;

  logic s1_valid, s2_valid, s3_valid;
  coord_t s1_x;
  logic [YMUL_BITS-1:0] s1_ymul, ymul;
  logic [INDEX_BITS-1:0] s1_zmul;
  logic [ZMUL_BITS-1:0] zmul;
  logic [1:0] s1_flags, s2_flags, s3_flags;
  logic [INDEX_BITS-1:0] s2_idx, s3_idx;
  logic [BMUL_BITS-1:0] bmul;
  logic [BYTE_BITS-1:0] s3_byte;

  result_t outq [OUT_DEPTH];
  logic [OPTR_BITS-1:0] wptr, rptr;
  logic [OPTR_BITS:0] ocount, inflight;
  logic do_pop;

  assign inflight = (OPTR_BITS + 1)'(s1_valid) + (OPTR_BITS + 1)'(s2_valid)
                    + (OPTR_BITS + 1)'(s3_valid);
  assign q_rd = !q_empty && (ocount + inflight < (OPTR_BITS + 1)'(OUT_DEPTH));
  assign ymul = {{EXT_BITS{1'b0}}, q_data.y} * {{DIM_BITS{1'b0}}, dx};
  assign zmul = {{DXY_BITS{1'b0}}, q_data.z} * {{DIM_BITS{1'b0}}, dxdy};
  assign bmul = {{EB_BITS{1'b0}}, s2_idx} * {{INDEX_BITS{1'b0}}, eb};
  assign empty = ocount == '0;
  assign do_pop = pop && !empty;
  assign res = outq[rptr];

  always_ff @(posedge clk) begin
    s1_x <= q_data.x;
    s1_ymul <= ymul;
    s1_zmul <= zmul[INDEX_BITS-1:0];
    s1_flags <= {q_data.chunk_last, q_data.volume_last};
    s2_idx <= INDEX_BITS'(s1_x) + INDEX_BITS'(s1_ymul) + s1_zmul;
    s2_flags <= s1_flags;
    s3_idx <= s2_idx;
    s3_byte <= bmul[BYTE_BITS-1:0];
    s3_flags <= s2_flags;
    if (s3_valid) begin
      outq[wptr] <= '{element_index: s3_idx, byte_offset: s3_byte,
                      chunk_last: s3_flags[1], volume_last: s3_flags[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      wptr <= '0;
      rptr <= '0;
      ocount <= '0;
    end else begin
      s1_valid <= q_rd;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      if (s3_valid) begin
        wptr <= wptr + OPTR_BITS'(1);
      end
      if (do_pop) begin
        rptr <= rptr + OPTR_BITS'(1);
      end
      ocount <= ocount + (OPTR_BITS + 1)'(s3_valid) - (OPTR_BITS + 1)'(do_pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> ocount < (OPTR_BITS + 1)'(OUT_DEPTH))
    else $error("result queue written while full");

  a_credit: assert property (@(posedge clk) disable iff (rst)
    ocount + inflight <= (OPTR_BITS + 1)'(OUT_DEPTH))
    else $error("results in flight exceed queue space");

  a_issue_has_item: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> !q_empty)
    else $error("read from empty item queue");

  a_pipe_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> s2_valid)
    else $error("item lost between pipeline stages");
`endif

endmodule

// ===== hw/rtl/chunked_volume_address_generator_core.sv =====
// Chunked volume address generator. It walks an x-fastest 3D volume in
// chunked order and gives, for each transfer on the input queue, the linear
// index and byte offset of one element plus end-of-chunk and end-of-volume
// flags. The restart field of an input transfer returns the walk to the
// origin before that element is generated.
// Input side: push with restart; a transfer happens when push is high and
// full is low. Result side: the oldest result sits on the result ports while
// empty is low and is taken when pop is high.
// Configuration: cfg_valid, cfg_index, cfg_data, with cfg_ready always high.
// The user must write registers only while the block holds no pending items;
// the block itself does not enforce this. One item is accepted per cycle while
// full is low, through the walker and the three-stage multiply pipeline
// behind a four-entry item queue.
// When the receiver stops popping, the eight-entry result queue fills, the
// pipeline stops taking items, the item queue fills and full rises.
// Reset clears the walk position and both queues, and sets every
// configuration register to one.
module chunked_volume_address_generator_core import cvag_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic                      restart,
  output logic                      empty,
  input  logic                      pop,
  output logic [INDEX_BITS-1:0]     element_index,
  output logic [BYTE_BITS-1:0]      byte_offset,
  output logic                      chunk_last,
  output logic                      volume_last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  logic [CFG_DATA_BITS-1:0] dim_x, dim_y, dim_z, chunk_x, chunk_y, chunk_z;
  logic [EB_BITS-1:0] element_bytes, eb;
  logic [DXY_BITS-1:0] dxdy;
  logic [2*EXT_BITS-1:0] dxdy_full;
  geom_t geom;
  logic q_wr, q_rd, q_empty;
  item_t q_wdata, q_rdata;
  result_t res;

  assign cfg_ready = 1'b1;

  always_comb begin
    geom.dx = clamp_dim(dim_x);
    geom.dy = clamp_dim(dim_y);
    geom.dz = clamp_dim(dim_z);
    geom.cx = clamp_chunk(chunk_x, geom.dx);
    geom.cy = clamp_chunk(chunk_y, geom.dy);
    geom.cz = clamp_chunk(chunk_z, geom.dz);
    eb = clamp_eb(element_bytes);
  end

  assign dxdy_full = {{EXT_BITS{1'b0}}, geom.dx} * {{EXT_BITS{1'b0}}, geom.dy};

  always_ff @(posedge clk) begin
    dxdy <= dxdy_full[DXY_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_x <= CFG_DATA_BITS'(1);
      dim_y <= CFG_DATA_BITS'(1);
      dim_z <= CFG_DATA_BITS'(1);
      chunk_x <= CFG_DATA_BITS'(1);
      chunk_y <= CFG_DATA_BITS'(1);
      chunk_z <= CFG_DATA_BITS'(1);
      element_bytes <= EB_BITS'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DIM_X: dim_x <= cfg_data;
        REG_DIM_Y: dim_y <= cfg_data;
        REG_DIM_Z: dim_z <= cfg_data;
        REG_CHUNK_X: chunk_x <= cfg_data;
        REG_CHUNK_Y: chunk_y <= cfg_data;
        REG_CHUNK_Z: chunk_z <= cfg_data;
        REG_ELEMENT_BYTES: element_bytes <= cfg_data[EB_BITS-1:0];
        default: ;
      endcase
    end
  end

  cvag_walker u_walker (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .restart (restart),
    .geom    (geom),
    .q_full  (full),
    .q_wr    (q_wr),
    .q_data  (q_wdata)
  );

  cvag_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  cvag_address u_address (
    .clk     (clk),
    .rst     (rst),
    .dx      (geom.dx),
    .dxdy    (dxdy),
    .eb      (eb),
    .q_data  (q_rdata),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .res     (res),
    .empty   (empty),
    .pop     (pop)
  );

  assign element_index = res.element_index;
  assign byte_offset = res.byte_offset;
  assign chunk_last = res.chunk_last;
  assign volume_last = res.volume_last;

endmodule
